>>> rtl/tpts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the timer pool tick scheduler.
// No dependencies; imported by every module of the block.
package tpts_pkg;

  localparam int unsigned ElapsedW   = 24;
  localparam logic [ElapsedW-1:0] ElapsedMax = 24'hFF_FFFF;
  localparam int unsigned MaxResults = 16;
  localparam logic [7:0]  TpsReset   = 8'd40;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_CLOSE  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CREATED = 3'd0,
    ST_FULL    = 3'd1,
    ST_DONE    = 3'd2,
    ST_NOALLOC = 3'd3,
    ST_EXPIRED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_CMD_WR,
    S_SWEEP,
    S_FLUSH
  } state_e;

  // One timer entry as held in the entry memory.
  typedef struct packed {
    logic                rep;
    logic [15:0]         period;
    logic [ElapsedW-1:0] elapsed;
    logic [15:0]         owner;
  } entry_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  id;
    logic [15:0] owner;
    logic        rep;
    logic [15:0] period;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  timer;
    logic [15:0] owner;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
    logic last;
  } push_t;

endpackage

>>> rtl/timer_pool_tick_scheduler_unit.sv
`timescale 1ns / 1ps
// Timer pool tick scheduler, top level: configuration register, output
// register and the sequencer with its entry memory. Depends on tpts_pkg.
//
// Usage: commands enter on the s_axis channel (tuser = command, tdata =
// timer id, owner, repeat flag, period). Results leave on m_axis (tuser =
// status, tdata = timer and owner, tlast marks the final result of a command).
// ticks_per_second is written on the cfg channel, always ready; the user must write
// it only while idle, which the block leaves unchecked. One command is taken at a
// time; s_axis_tready is high only when idle. Command sequences:
//   start, stop, close: entry read, then S_CMD_WR, then the result from S_FLUSH;
//   bad timer id: a NOALLOC result straight from S_FLUSH;
//   create: scan for the lowest free entry, then S_FLUSH (FULL if none is free);
//   tick: the sweep visits one entry per cycle, unless stalled, reading active entries
//   through the single memory read port; the final result comes from S_FLUSH, and a
//   tick with no expiry gives no result.
// A stalled m_axis holds its transaction; the sweep freezes only when a
// second expiry result is waiting, and resumes once the receiver takes one.
// Reset frees and deactivates every timer and sets ticks_per_second to 40;
// entry memory contents need no clearing, as an entry is written on create.
module timer_pool_tick_scheduler_unit #(
  parameter int unsigned TIMER_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // ticks_per_second
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // timer_id, owner_handle, repeat_req, period_seconds
  input  logic [2:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // result_timer, result_owner
  output logic [2:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast
);
  import tpts_pkg::*;

  localparam int unsigned IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  logic [7:0]      tps_q;
  req_t            req;
  push_t           push;
  logic            slot_free;
  logic            out_v_q;
  res_t            out_res_q;
  logic            out_last_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
    end else if (cfg_valid_i) begin
      tps_q <= cfg_data_i;
    end
  end

  assign req = '{cmd: s_axis_tuser, id: s_axis_tdata[3:0], owner: s_axis_tdata[19:4],
                 rep: s_axis_tdata[20], period: s_axis_tdata[36:21]};

  assign slot_free = !out_v_q || m_axis_tready;

  tpts_ctrl #(
    .TimerCount (TIMER_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tps_i       (tps_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_i       (req),
    .slot_free_i (slot_free),
    .push_o      (push),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  tpts_entry_ram #(
    .Depth (TIMER_COUNT)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // hold the result transaction until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (push.valid) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_res_q  <= push.res;
      out_last_q <= push.last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, out_res_q.owner, out_res_q.timer};
  assign m_axis_tuser  = 3'(out_res_q.status);
  assign m_axis_tlast  = out_last_q;

  a_push_into_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> (!out_v_q || m_axis_tready))
    else $error("result pushed over a held transaction");

  a_idle_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !push.valid)
    else $error("result produced while idle");

  a_last_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.valid && push.last) |=> s_axis_tready)
    else $error("not idle after final result");

endmodule

>>> rtl/tpts_entry_ram.sv
`timescale 1ns / 1ps
// Timer entry memory: one write port, one read port, registered read data.
// Depends on tpts_pkg for the entry layout.
module tpts_entry_ram #(
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output tpts_pkg::entry_t                            rd_data_o,
  input  logic                                        wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  tpts_pkg::entry_t                            wr_data_i
);
  import tpts_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/tpts_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: allocation scan, start read-modify-write, stop/close read and
// flag update, and the pipelined tick sweep over the entry memory. Depends on tpts_pkg.
module tpts_ctrl #(
  parameter int unsigned TimerCount = 16
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic [7:0]                                        tps_i,
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  tpts_pkg::req_t                                    req_i,
  input  logic                                              slot_free_i,
  output tpts_pkg::push_t                                   push_o,
  output logic                                              rd_en_o,
  output logic [((TimerCount > 1) ? $clog2(TimerCount) : 1)-1:0] rd_addr_o,
  input  tpts_pkg::entry_t                                  rd_data_i,
  output logic                                              wr_en_o,
  output logic [((TimerCount > 1) ? $clog2(TimerCount) : 1)-1:0] wr_addr_o,
  output tpts_pkg::entry_t                                  wr_data_o
);
  import tpts_pkg::*;

  localparam int unsigned IdxW  = (TimerCount > 1) ? $clog2(TimerCount) : 1;
  localparam int unsigned CntW  = $clog2(TimerCount + 1);
  localparam int unsigned NresW = $clog2(MaxResults + 1);
  localparam logic [CntW-1:0] ScanEnd = CntW'(TimerCount);

  state_e               state_q, state_d;
  logic [CntW-1:0]      scan_q, scan_d;
  req_t                 req_q, req_d;
  logic                 s1_v_q, s1_v_d;
  logic [IdxW-1:0]      s1_idx_q, s1_idx_d;
  logic                 s2_v_q, s2_v_d;
  logic [IdxW-1:0]      s2_idx_q, s2_idx_d;
  entry_t               s2_ent_q, s2_ent_d;
  logic [ElapsedW-1:0]  s2_limit_q, s2_limit_d;
  logic                 pend_v_q, pend_v_d;
  res_t                 pend_q, pend_d;
  logic [NresW-1:0]     nres_q, nres_d;
  logic [TimerCount-1:0] alloc_q, alloc_d;
  logic [TimerCount-1:0] active_q, active_d;

  logic [IdxW-1:0]      scan_idx;
  logic [IdxW-1:0]      in_idx;
  logic [IdxW-1:0]      req_idx;
  logic                 in_id_ok;
  logic                 expire;
  logic                 report;
  logic                 stall;
  entry_t               wb_ent;

  assign scan_idx = scan_q[IdxW-1:0];
  assign in_idx   = IdxW'(req_i.id);
  assign req_idx  = IdxW'(req_q.id);
  assign in_id_ok = (32'(req_i.id) < 32'(TimerCount)) && alloc_q[in_idx];
  assign expire   = s2_ent_q.elapsed >= s2_limit_q;
  assign report   = expire && (nres_q < NresW'(MaxResults));
  assign stall    = s2_v_q && report && pend_v_q && !slot_free_i;

  always_comb begin
    wb_ent         = s2_ent_q;
    wb_ent.elapsed = expire ? '0 : s2_ent_q.elapsed;
  end

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    req_d      = req_q;
    s1_v_d     = s1_v_q;
    s1_idx_d   = s1_idx_q;
    s2_v_d     = s2_v_q;
    s2_idx_d   = s2_idx_q;
    s2_ent_d   = s2_ent_q;
    s2_limit_d = s2_limit_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    nres_d     = nres_q;
    alloc_d    = alloc_q;
    active_d   = active_q;
    in_ready_o = 1'b0;
    push_o     = '0;
    rd_en_o    = 1'b0;
    rd_addr_o  = scan_idx;
    wr_en_o    = 1'b0;
    wr_addr_o  = s2_idx_q;
    wr_data_o  = wb_ent;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d    = req_i;
          scan_d   = '0;
          nres_d   = '0;
          pend_v_d = 1'b0;
          s1_v_d   = 1'b0;
          s2_v_d   = 1'b0;
          case (cmd_e'(req_i.cmd))
            CMD_CREATE: begin
              state_d = S_ALLOC;
            end
            CMD_START, CMD_STOP, CMD_CLOSE: begin
              if (in_id_ok) begin
                rd_en_o   = 1'b1;
                rd_addr_o = in_idx;
                state_d   = S_CMD_WR;
              end else begin
                pend_d   = '{status: ST_NOALLOC, timer: req_i.id, owner: 16'd0};
                pend_v_d = 1'b1;
                state_d  = S_FLUSH;
              end
            end
            CMD_TICK: begin
              state_d = S_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (scan_q == ScanEnd) begin
          pend_d   = '{status: ST_FULL, timer: 4'd0, owner: req_q.owner};
          pend_v_d = 1'b1;
          state_d  = S_FLUSH;
        end else if (!alloc_q[scan_idx]) begin
          wr_en_o   = 1'b1;
          wr_addr_o = scan_idx;
          wr_data_o = '{rep: 1'b0, period: 16'd0, elapsed: '0, owner: req_q.owner};
          alloc_d[scan_idx]  = 1'b1;
          active_d[scan_idx] = 1'b0;
          pend_d   = '{status: ST_CREATED, timer: 4'(scan_q), owner: req_q.owner};
          pend_v_d = 1'b1;
          state_d  = S_FLUSH;
        end else begin
          scan_d = scan_q + CntW'(1);
        end
      end

      S_CMD_WR: begin
        case (cmd_e'(req_q.cmd))
          CMD_START: begin
            wr_en_o   = 1'b1;
            wr_addr_o = req_idx;
            wr_data_o = '{rep: req_q.rep, period: req_q.period,
                          elapsed: rd_data_i.elapsed, owner: rd_data_i.owner};
            active_d[req_idx] = 1'b1;
          end
          CMD_STOP: begin
            active_d[req_idx] = 1'b0;
          end
          CMD_CLOSE: begin
            active_d[req_idx] = 1'b0;
            alloc_d[req_idx]  = 1'b0;
          end
          default: begin
          end
        endcase
        pend_d   = '{status: ST_DONE, timer: req_q.id, owner: rd_data_i.owner};
        pend_v_d = 1'b1;
        state_d  = S_FLUSH;
      end

      S_SWEEP: begin
        if (!stall) begin
          // write back and report the entry in the last stage
          if (s2_v_q) begin
            wr_en_o = 1'b1;
            if (expire && !s2_ent_q.rep) begin
              active_d[s2_idx_q] = 1'b0;
            end
            if (report) begin
              if (pend_v_q) begin
                push_o = '{valid: 1'b1, res: pend_q, last: 1'b0};
              end
              pend_d   = '{status: ST_EXPIRED, timer: 4'(s2_idx_q), owner: s2_ent_q.owner};
              pend_v_d = 1'b1;
              nres_d   = nres_q + NresW'(1);
            end
          end
          // advance the count and form the expiry limit
          s2_v_d           = s1_v_q;
          s2_idx_d         = s1_idx_q;
          s2_ent_d         = rd_data_i;
          s2_ent_d.elapsed = (rd_data_i.elapsed == ElapsedMax) ? rd_data_i.elapsed
                                                               : rd_data_i.elapsed + 24'd1;
          s2_limit_d       = 24'(tps_i) * 24'(rd_data_i.period);
          // read the next active entry
          if (scan_q != ScanEnd) begin
            rd_en_o  = active_q[scan_idx];
            s1_v_d   = active_q[scan_idx];
            s1_idx_d = scan_idx;
            scan_d   = scan_q + CntW'(1);
          end else begin
            s1_v_d = 1'b0;
          end
          if (scan_q == ScanEnd && !s1_v_q && !s2_v_q) begin
            state_d = pend_v_q ? S_FLUSH : S_IDLE;
          end
        end
      end

      S_FLUSH: begin
        if (slot_free_i) begin
          push_o   = '{valid: 1'b1, res: pend_q, last: 1'b1};
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scan_q   <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      nres_q   <= '0;
      alloc_q  <= '0;
      active_q <= '0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      s1_v_q   <= s1_v_d;
      s2_v_q   <= s2_v_d;
      pend_v_q <= pend_v_d;
      nres_q   <= nres_d;
      alloc_q  <= alloc_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    s1_idx_q   <= s1_idx_d;
    s2_idx_q   <= s2_idx_d;
    s2_ent_q   <= s2_ent_d;
    s2_limit_q <= s2_limit_d;
    pend_q     <= pend_d;
  end

endmodule
